// File: src/raec_pkg.sv
// Shared types, widths and codes for the region adjacency edge counter.
package raec_pkg;

    localparam int VERTEX_W     = 12;
    localparam int LABEL_W      = 6;
    localparam int COUNT_W      = 16;
    localparam int NREG_W       = 7;
    localparam int PAIR_AW      = 2 * LABEL_W;
    localparam int MAX_VERTICES = 1 << VERTEX_W;
    localparam int MAX_REGIONS  = 1 << LABEL_W;
    localparam int PAIR_DEPTH   = 1 << PAIR_AW;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [NREG_W-1:0]  ACTIVE_REGIONS_RST = NREG_W'(MAX_REGIONS);
    localparam logic [NREG_W-1:0]  REGION_CAP         = NREG_W'(MAX_REGIONS);
    localparam logic [COUNT_W-1:0] COUNT_MAX          = {COUNT_W{1'b1}};

    localparam logic CFG_IDX_ACTIVE_REGIONS = 1'b0;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [VERTEX_W-1:0] vertex;
        logic [VERTEX_W-1:0] neighbour;
        logic [LABEL_W-1:0]  label;
        logic [LABEL_W-1:0]  query_a;
        logic [LABEL_W-1:0]  query_b;
    } t_in_data;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] edge_count;
    } t_out_data;

    typedef struct packed {
        logic capture;
        logic clr;
        logic lbl_wr;
        logic lbl_rd_src;
        logic lbl_rd_dst;
        logic cap_ra;
        logic edge_eval;
        logic pair_wr;
        logic qry_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_opcode;
        logic       clr_last;
    } t_sts;

    function automatic logic label_ok(input logic [LABEL_W-1:0] lbl,
                                      input logic [NREG_W-1:0] limit);
        label_ok = NREG_W'(lbl) < limit;
    endfunction

endpackage

// File: src/raec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module raec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/raec_ctrl.sv
// Controller state machine that sequences clearing, label loads, edge updates and reads.
module raec_ctrl import raec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_LBL_A = 4'd3;
    localparam logic [3:0] S_LBL_B = 4'd4;
    localparam logic [3:0] S_LBL_C = 4'd5;
    localparam logic [3:0] S_INC   = 4'd6;
    localparam logic [3:0] S_QRY   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_sts.in_opcode)
                        OP_LOAD: n_state = S_LOAD;
                        OP_EDGE: n_state = S_LBL_A;
                        OP_READ: n_state = S_QRY;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.lbl_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_LBL_A: begin
                o_cmd.lbl_rd_src = 1'b1;
                n_state          = S_LBL_B;
            end
            S_LBL_B: begin
                o_cmd.lbl_rd_dst = 1'b1;
                o_cmd.cap_ra     = 1'b1;
                n_state          = S_LBL_C;
            end
            S_LBL_C: begin
                o_cmd.edge_eval = 1'b1;
                n_state         = S_INC;
            end
            S_INC: begin
                o_cmd.pair_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_QRY: begin
                o_cmd.qry_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    // A result must never overwrite one that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    // An accepted item always leaves the idle state for its work.
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

    // A new result only appears from the completion state.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without completion");

    // The count store is written back only right after its read.
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pair_wr |-> ($past(r_state) == S_LBL_C))
        else $error("count write without preceding read");

endmodule

// File: src/raec_dp.sv
// Datapath with the label table, the pair count store and the result register.
module raec_dp import raec_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  t_in_data          i_in_data,
    input  logic [NREG_W-1:0] i_active_regions,
    output t_out_data         o_out_data
);

    t_in_data             r_in;
    logic [LABEL_W-1:0]   r_ra;
    logic [LABEL_W-1:0]   r_rb;
    logic                 r_err;
    logic                 r_inc_ok;
    logic [PAIR_AW-1:0]   r_clr_addr;
    t_out_data            r_out;
    t_out_data            n_out;

    logic [NREG_W-1:0]    limit;
    logic [LABEL_W-1:0]   lbl_rdata;
    logic [LABEL_W-1:0]   lbl_raddr;
    logic [VERTEX_W-1:0]  lbl_raddr_v;
    logic                 lbl_we;
    logic [COUNT_W-1:0]   pair_rdata;
    logic [COUNT_W-1:0]   pair_wdata;
    logic [PAIR_AW-1:0]   pair_waddr;
    logic [PAIR_AW-1:0]   pair_raddr;
    logic                 pair_we;
    logic                 pair_re;
    logic [LABEL_W-1:0]   q_lo;
    logic [LABEL_W-1:0]   q_hi;
    logic                 qa_ok;
    logic                 qb_ok;
    logic                 rb_ok;
    logic                 ra_ok;

    assign limit = (i_active_regions > REGION_CAP) ? REGION_CAP : i_active_regions;
    assign qa_ok = label_ok(r_in.query_a, limit);
    assign qb_ok = label_ok(r_in.query_b, limit);
    assign ra_ok = label_ok(r_ra, limit);
    assign rb_ok = label_ok(lbl_rdata, limit);
    assign q_lo  = (r_in.query_a < r_in.query_b) ? r_in.query_a : r_in.query_b;
    assign q_hi  = (r_in.query_a < r_in.query_b) ? r_in.query_b : r_in.query_a;

    assign lbl_raddr_v = i_cmd.lbl_rd_src ? r_in.vertex : r_in.neighbour;
    assign lbl_we      = i_cmd.lbl_wr && label_ok(r_in.label, limit);
    assign lbl_raddr   = lbl_rdata;

    raec_ram #(
        .WIDTH(LABEL_W),
        .DEPTH(MAX_VERTICES)
    ) u_label_ram (
        .i_clk  (i_clk),
        .i_we   (lbl_we),
        .i_waddr(r_in.vertex),
        .i_wdata(r_in.label),
        .i_re   (i_cmd.lbl_rd_src || i_cmd.lbl_rd_dst),
        .i_raddr(lbl_raddr_v),
        .o_rdata(lbl_rdata)
    );

    assign pair_we    = i_cmd.clr || (i_cmd.pair_wr && r_inc_ok);
    assign pair_waddr = i_cmd.clr ? r_clr_addr : {r_ra, r_rb};
    assign pair_re    = i_cmd.edge_eval || i_cmd.qry_rd;
    assign pair_raddr = i_cmd.qry_rd ? {q_lo, q_hi} : {r_ra, lbl_raddr};

    always_comb begin
        if (i_cmd.clr) begin
            pair_wdata = '0;
        end else if (pair_rdata == COUNT_MAX) begin
            pair_wdata = pair_rdata;
        end else begin
            pair_wdata = pair_rdata + COUNT_W'(1);
        end
    end

    raec_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(PAIR_DEPTH)
    ) u_pair_ram (
        .i_clk  (i_clk),
        .i_we   (pair_we),
        .i_waddr(pair_waddr),
        .i_wdata(pair_wdata),
        .i_re   (pair_re),
        .i_raddr(pair_raddr),
        .o_rdata(pair_rdata)
    );

    always_comb begin
        n_out.status     = ST_OK;
        n_out.edge_count = '0;
        case (r_in.opcode)
            OP_LOAD: begin
                n_out.status = label_ok(r_in.label, limit) ? ST_OK : ST_ERR;
            end
            OP_EDGE: begin
                n_out.status = r_err ? ST_ERR : ST_OK;
            end
            OP_READ: begin
                if (!(qa_ok && qb_ok)) begin
                    n_out.status = ST_ERR;
                end else if (r_in.query_a != r_in.query_b) begin
                    n_out.edge_count = pair_rdata;
                end
            end
            default: begin
                n_out.status = ST_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + PAIR_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.cap_ra) begin
            r_ra <= lbl_rdata;
        end
        if (i_cmd.edge_eval) begin
            r_rb     <= lbl_rdata;
            r_err    <= !(ra_ok && rb_ok);
            r_inc_ok <= ra_ok && rb_ok && (r_ra < lbl_rdata);
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_sts.in_opcode = i_in_data.opcode;
    assign o_sts.clr_last  = (r_clr_addr == {PAIR_AW{1'b1}});
    assign o_out_data      = r_out;

endmodule

// File: src/region_adjacency_edge_counter_unit.sv
// Top level of the region adjacency edge counter with its configuration port.
// From input transfer to result valid, a label load passes the load and done states, a pair read
// the query and done states, an adjacency entry two label reads, evaluation, increment and done,
// and an unused opcode only the done state. One item is in work at a time: a new item is taken
// only after the last result is loaded, and the two label table reads share one read port.
// Reset starts a clear of all 4096 count store entries with input held off and 64 regions active.
module region_adjacency_edge_counter_unit import raec_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_data           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_data          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [NREG_W-1:0] r_active_regions;
    logic              cfg_sel;
    t_cmd              cmd;
    t_sts              sts;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1] == CFG_IDX_ACTIVE_REGIONS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_regions <= ACTIVE_REGIONS_RST;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_active_regions <= pwdata[NREG_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(PDATA_W - NREG_W){1'b0}}, r_active_regions} : '0;

    raec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    raec_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_data       (i_in_data),
        .i_active_regions(r_active_regions),
        .o_out_data      (o_out_data)
    );

endmodule

// File: test/raec_checker.sv
// Checker that mirrors the edge counter state, predicts each result and compares it.
module raec_checker import raec_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_data           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_data          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic [PADDR_W-1:0] ACTIVE_REGIONS_ADDR = {CFG_IDX_ACTIVE_REGIONS, 2'b00};

    logic [LABEL_W-1:0] vertex_region [MAX_VERTICES];
    logic [COUNT_W-1:0] pair_edges [MAX_REGIONS][MAX_REGIONS];
    logic [NREG_W-1:0]  region_count = ACTIVE_REGIONS_RST;
    t_out_data          expected_results [$];
    int                 errors = 0;

    function automatic t_out_data predict_result(input t_in_data it);
        t_out_data          res;
        logic [NREG_W-1:0]  lim;
        logic [LABEL_W-1:0] ra;
        logic [LABEL_W-1:0] rb;
        res.status     = ST_OK;
        res.edge_count = '0;
        lim = (region_count < REGION_CAP) ? region_count : REGION_CAP;
        case (it.opcode)
            OP_LOAD: begin
                if (NREG_W'(it.label) < lim) begin
                    vertex_region[it.vertex] = it.label;
                end else begin
                    res.status = ST_ERR;
                end
            end
            OP_EDGE: begin
                ra = vertex_region[it.vertex];
                rb = vertex_region[it.neighbour];
                if (NREG_W'(ra) >= lim || NREG_W'(rb) >= lim) begin
                    res.status = ST_ERR;
                end else if (ra < rb && pair_edges[ra][rb] != COUNT_MAX) begin
                    pair_edges[ra][rb] = pair_edges[ra][rb] + 1'b1;
                end
            end
            OP_READ: begin
                if (NREG_W'(it.query_a) >= lim || NREG_W'(it.query_b) >= lim) begin
                    res.status = ST_ERR;
                end else if (it.query_a < it.query_b) begin
                    res.edge_count = pair_edges[it.query_a][it.query_b];
                end else if (it.query_b < it.query_a) begin
                    res.edge_count = pair_edges[it.query_b][it.query_a];
                end
            end
            default: begin
                res.status = ST_ERR;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_data want;
        if (!i_rst_n) begin
            region_count = ACTIVE_REGIONS_RST;
            foreach (pair_edges[a, b]) pair_edges[a][b] = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: status %0d, count %0d",
                             $time, i_out_data.status, i_out_data.edge_count);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_out_data.status);
                        errors++;
                    end
                    if (i_out_data.edge_count !== want.edge_count) begin
                        $display("%0t: edge_count mismatch: expected %0d, got %0d",
                                 $time, want.edge_count, i_out_data.edge_count);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_result(i_in_data));
            end
            if (i_psel && i_penable && i_pready && i_paddr == ACTIVE_REGIONS_ADDR) begin
                if (i_pwrite) begin
                    region_count = i_pwdata[NREG_W-1:0];
                end else if (i_prdata !== PDATA_W'(region_count)) begin
                    $display("%0t: region count readback mismatch: expected %0d, got %0d",
                             $time, region_count, i_prdata);
                    errors++;
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_results.size();
    end

endmodule

// File: test/region_adjacency_edge_counter_unit_tb.sv
// Testbench top that drives items and register writes into the edge counter and gives the verdict.
module region_adjacency_edge_counter_unit_tb;
    import raec_pkg::*;

    localparam int RUN_LIMIT   = 2_000_000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_SIZE   = 16;
    localparam int LABEL_SET   = 6;

    localparam logic [1:0]         OP_SPARE            = 2'd3;
    localparam logic [PADDR_W-1:0] ACTIVE_REGIONS_ADDR = {CFG_IDX_ACTIVE_REGIONS, 2'b00};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_data           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_data          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    bit  loaded_map [MAX_VERTICES];
    int  loaded_list [$];
    int  vertex_pool [POOL_SIZE];
    int  region_limit = MAX_REGIONS;
    int  stall_left   = 0;
    bit  idle_on      = 1'b1;
    int  n_load       = 0;
    int  n_edge       = 0;
    int  n_read       = 0;
    int  n_spare      = 0;
    int  n_settings   = 0;

    region_adjacency_edge_counter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    raec_checker results_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_data build_item(input logic [1:0] op, input int a, input int b);
        t_in_data    it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it  = raw[$bits(t_in_data)-1:0];
        it.opcode = op;
        case (op)
            OP_LOAD: begin
                it.vertex = VERTEX_W'(a);
                it.label  = LABEL_W'(b);
            end
            OP_EDGE: begin
                it.vertex    = VERTEX_W'(a);
                it.neighbour = VERTEX_W'(b);
            end
            OP_READ: begin
                it.query_a = LABEL_W'(a);
                it.query_b = LABEL_W'(b);
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    // Only vertices whose label was actually stored may appear in an adjacency entry.
    function automatic int pick_loaded(input bit from_history);
        int cands [$];
        if (!from_history) begin
            foreach (vertex_pool[k]) begin
                if (loaded_map[vertex_pool[k]]) cands.push_back(vertex_pool[k]);
            end
        end
        if (cands.size() == 0) return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    task automatic send_item(input t_in_data it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        case (it.opcode)
            OP_LOAD: n_load++;
            OP_EDGE: n_edge++;
            OP_READ: n_read++;
            default: n_spare++;
        endcase
        if (it.opcode == OP_LOAD && int'(it.label) < region_limit && !loaded_map[it.vertex]) begin
            loaded_map[it.vertex] = 1'b1;
            loaded_list.push_back(int'(it.vertex));
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ACTIVE_REGIONS_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_region_count(input int value);
        apb_access(1'b1, PDATA_W'(value));
        apb_access(1'b0, '0);
        region_limit = ((value & 127) < MAX_REGIONS) ? (value & 127) : MAX_REGIONS;
        n_settings++;
    endtask

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("region_adjacency_edge_counter_unit_tb: errors");
        $finish;
    end

    initial begin
        int       lbl_set [LABEL_SET];
        int       r;
        int       a;
        int       b;
        t_in_data it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_region_count(MAX_REGIONS);

        send_item(build_item(OP_LOAD, 0, 0));
        send_item(build_item(OP_LOAD, MAX_VERTICES - 1, MAX_REGIONS - 1));
        send_item(build_item(OP_LOAD, 'hAAA, 21));
        send_item(build_item(OP_LOAD, 'h555, 42));
        send_item(build_item(OP_EDGE, 0, MAX_VERTICES - 1));
        send_item(build_item(OP_EDGE, MAX_VERTICES - 1, 0));
        send_item(build_item(OP_EDGE, 'hAAA, 'h555));
        send_item(build_item(OP_EDGE, 'h555, 'h555));
        send_item(build_item(OP_READ, 0, MAX_REGIONS - 1));
        send_item(build_item(OP_READ, MAX_REGIONS - 1, 0));
        send_item(build_item(OP_READ, 42, 21));
        send_item(build_item(OP_READ, 5, 5));
        send_item(build_item(OP_SPARE, 0, 0));

        wait_idle();
        set_region_count(1);
        send_item(build_item(OP_LOAD, 'h123, 1));
        send_item(build_item(OP_LOAD, 'h123, 0));
        send_item(build_item(OP_EDGE, 0, MAX_VERTICES - 1));
        send_item(build_item(OP_READ, 0, 1));
        send_item(build_item(OP_READ, 0, 0));

        wait_idle();
        set_region_count(0);
        send_item(build_item(OP_LOAD, 'h321, 0));
        send_item(build_item(OP_EDGE, 0, 'h123));
        send_item(build_item(OP_READ, 0, 0));

        wait_idle();
        set_region_count(127);
        send_item(build_item(OP_READ, 0, MAX_REGIONS - 1));
        send_item(build_item(OP_LOAD, 'h0F0, 0));
        send_item(build_item(OP_LOAD, 'hF0F, MAX_REGIONS - 1));
        send_item(build_item(OP_READ, MAX_REGIONS - 1, MAX_REGIONS - 1));
        send_item(build_item(OP_EDGE, 'h0F0, 'hF0F));
        send_item(build_item(OP_READ, MAX_REGIONS - 1, 0));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: set_region_count(MAX_REGIONS);
                1: set_region_count(2);
                2: set_region_count(127);
                3: set_region_count($urandom_range(3, 63));
                4: set_region_count(1);
                5: set_region_count($urandom_range(0, 127));
                default: set_region_count(MAX_REGIONS);
            endcase
            foreach (vertex_pool[k]) vertex_pool[k] = $urandom_range(0, MAX_VERTICES - 1);
            foreach (lbl_set[k]) begin
                lbl_set[k] = (region_limit == 0) ? 0 : $urandom_range(0, region_limit - 1);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    a = (r < 3) ? $urandom_range(0, MAX_VERTICES - 1)
                                : vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
                    b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_REGIONS - 1)
                                                    : lbl_set[$urandom_range(0, LABEL_SET - 1)];
                    it = build_item(OP_LOAD, a, b);
                end else if (r < 75) begin
                    it = build_item(OP_EDGE, pick_loaded(r < 40), pick_loaded(r < 40));
                end else if (r < 95) begin
                    if (r < 79) begin
                        a = $urandom_range(0, MAX_REGIONS - 1);
                        b = $urandom_range(0, MAX_REGIONS - 1);
                    end else begin
                        a = lbl_set[$urandom_range(0, LABEL_SET - 1)];
                        b = lbl_set[$urandom_range(0, LABEL_SET - 1)];
                    end
                    it = build_item(OP_READ, a, b);
                end else begin
                    it = build_item(OP_SPARE, 0, 0);
                end
                send_item(it);
            end
        end

        wait_idle();
        $display("Sent %0d label loads, %0d adjacency entries, %0d pair reads, %0d spare opcodes",
                 n_load, n_edge, n_read, n_spare);
        $display("under %0d region count settings, with rejected and stale labels included.",
                 n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("region_adjacency_edge_counter_unit_tb: clean");
        end else begin
            $display("region_adjacency_edge_counter_unit_tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
src/raec_pkg.sv
src/raec_ram.sv
src/raec_ctrl.sv
src/raec_dp.sv
src/region_adjacency_edge_counter_unit.sv
test/raec_checker.sv
test/region_adjacency_edge_counter_unit_tb.sv
